// ===== rtl/core/fclc_pkg.sv =====
// ----------------------------------------------------------------------------
// fclc_pkg
// Shared types, codes and threshold helpers of the fan curve level controller.
// ----------------------------------------------------------------------------
package fclc_pkg;

    localparam int TEMP_W    = 8;
    localparam int LEVEL_W   = 3;
    localparam int MODE_W    = 2;
    localparam int CMD_W     = 2;
    localparam int FAN_W     = 2;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_FANS  = 3;

    localparam int FCLC_QUEUE_DEPTH = 2;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd5;

    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_MODE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_AUTO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURVE = 2'd2;

    localparam logic [FAN_W-1:0] FAN_LAST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FAN1_RAMPUP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN1_RAMPDOWN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN2_RAMPUP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN2_RAMPDOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN3_RAMPUP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN3_RAMPDOWN = 3'd5;

    localparam logic [CFG_W-1:0] RST_FAN12_RAMPUP   = 40'd418211120700;
    localparam logic [CFG_W-1:0] RST_FAN12_RAMPDOWN = 40'd413899174440;
    localparam logic [CFG_W-1:0] RST_FAN3_RAMPUP    = 40'd418211118100;
    localparam logic [CFG_W-1:0] RST_FAN3_RAMPDOWN  = 40'd413899174400;

    // decoded operation codes
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_MODE  = 2'd2;
    localparam logic [1:0] OP_LEVEL = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [FAN_W-1:0]   fan;
        logic [TEMP_W-1:0]  temp;
        logic [LEVEL_W-1:0] value;
    } fclc_op_t;

    function automatic logic [TEMP_W-1:0] thr_byte(
        input logic [CFG_W-1:0]   r,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [TEMP_W-1:0] b;
        case (lvl)
            3'd1:    b = r[7:0];
            3'd2:    b = r[15:8];
            3'd3:    b = r[23:16];
            3'd4:    b = r[31:24];
            3'd5:    b = r[39:32];
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [LEVEL_W-1:0] fan_step(
        input logic [CFG_W-1:0]   up,
        input logic [CFG_W-1:0]   down,
        input logic [LEVEL_W-1:0] lvl,
        input logic [TEMP_W-1:0]  temp
    );
        logic [LEVEL_W-1:0] nxt;
        nxt = lvl;
        if (lvl < MAX_LEVEL && temp >= thr_byte(up, lvl + 3'd1))
        begin
            nxt = lvl + 3'd1;
        end
        else if (lvl != 3'd0 && temp <= thr_byte(down, lvl))
        begin
            nxt = lvl - 3'd1;
        end
        return nxt;
    endfunction

    function automatic logic [LEVEL_W-1:0] curve_entry(
        input logic [CFG_W-1:0]  up,
        input logic [TEMP_W-1:0] temp
    );
        logic [LEVEL_W-1:0] lvl;
        lvl = '0;
        for (int l = 1; l <= 5; l++)
        begin
            if (temp >= thr_byte(up, LEVEL_W'(l)))
            begin
                lvl = LEVEL_W'(l);
            end
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/core/fclc_if.sv =====
// ----------------------------------------------------------------------------
// fclc_if
// Request and status channels of the fan curve level controller.
// ----------------------------------------------------------------------------
interface fclc_cmd_if;
    import fclc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TEMP_W-1:0] temperature;
    logic [FAN_W-1:0]  fan_index;
    logic [TEMP_W-1:0] setting_value;

    modport source (output valid, command, temperature, fan_index, setting_value,
                    input ready);
    modport sink   (input valid, command, temperature, fan_index, setting_value,
                    output ready);
endinterface

interface fclc_status_if;
    import fclc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] fan1_level_out;
    logic [LEVEL_W-1:0] fan2_level_out;
    logic [LEVEL_W-1:0] fan3_level_out;
    logic [MODE_W-1:0]  fan1_mode_out;
    logic [MODE_W-1:0]  fan2_mode_out;
    logic [MODE_W-1:0]  fan3_mode_out;
    logic [TEMP_W-1:0]  lowest_temp;
    logic [TEMP_W-1:0]  highest_temp;

    modport source (output valid, fan1_level_out, fan2_level_out, fan3_level_out,
                    fan1_mode_out, fan2_mode_out, fan3_mode_out,
                    lowest_temp, highest_temp,
                    input ready);
    modport sink   (input valid, fan1_level_out, fan2_level_out, fan3_level_out,
                    fan1_mode_out, fan2_mode_out, fan3_mode_out,
                    lowest_temp, highest_temp,
                    output ready);
endinterface

// ===== rtl/core/fclc_front.sv =====
// ----------------------------------------------------------------------------
// fclc_front
// Accepts requests and classifies them into decoded operations.
// ----------------------------------------------------------------------------
module fclc_front (
    fclc_cmd_if.sink            cmd,
    input  logic                full,
    output logic                push,
    output fclc_pkg::fclc_op_t  entry
);
    import fclc_pkg::*;

    logic fan_ok;

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full;
    assign fan_ok    = cmd.fan_index <= FAN_LAST;

    always_comb
    begin
        entry.op    = OP_NOP;
        entry.fan   = cmd.fan_index;
        entry.temp  = cmd.temperature;
        entry.value = cmd.setting_value[LEVEL_W-1:0];
        unique case (cmd.command)
            CMD_TICK:
            begin
                entry.op = OP_TICK;
            end
            CMD_SET_MODE:
            begin
                if (fan_ok && cmd.setting_value <= TEMP_W'(MODE_CURVE))
                begin
                    entry.op = OP_MODE;
                end
            end
            CMD_SET_LEVEL:
            begin
                if (fan_ok)
                begin
                    entry.op = OP_LEVEL;
                end
                // clamp
                if (cmd.setting_value > TEMP_W'(MAX_LEVEL))
                begin
                    entry.value = MAX_LEVEL;
                end
            end
            default:
            begin
                entry.op = OP_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/core/fclc_queue.sv =====
// ----------------------------------------------------------------------------
// fclc_queue
// Small FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module fclc_queue #(
    parameter int DEPTH = fclc_pkg::FCLC_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fclc_pkg::fclc_op_t  wr_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output fclc_pkg::fclc_op_t  rd_entry,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import fclc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    fclc_op_t            store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_entry  = store_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/fclc_back.sv =====
// ----------------------------------------------------------------------------
// fclc_back
// Executes decoded operations on fan state and holds the status result.
// ----------------------------------------------------------------------------
module fclc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fclc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fclc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                q_valid,
    input  fclc_pkg::fclc_op_t                  q_entry,
    output logic                                q_pop,
    fclc_status_if.source                       status
);
    import fclc_pkg::*;

    logic [CFG_W-1:0]   up_reg        [NUM_FANS];
    logic [CFG_W-1:0]   down_reg      [NUM_FANS];
    logic [LEVEL_W-1:0] level_reg     [NUM_FANS];
    logic [LEVEL_W-1:0] level_next    [NUM_FANS];
    logic [MODE_W-1:0]  fan_mode_reg  [NUM_FANS];
    logic [MODE_W-1:0]  fan_mode_next [NUM_FANS];
    logic [TEMP_W-1:0]  min_reg;
    logic [TEMP_W-1:0]  min_next;
    logic [TEMP_W-1:0]  max_reg;
    logic [TEMP_W-1:0]  max_next;
    logic               valid_reg;
    logic               valid_next;

    assign q_pop = q_valid && (!valid_reg || status.ready);

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        for (int i = 0; i < NUM_FANS; i++)
        begin
            level_next[i]    = level_reg[i];
            fan_mode_next[i] = fan_mode_reg[i];
            unique case (q_entry.op)
                OP_TICK:
                begin
                    if (fan_mode_reg[i] == MODE_CURVE)
                    begin
                        level_next[i] = fan_step(up_reg[i], down_reg[i], level_reg[i],
                                                 q_entry.temp);
                    end
                end
                OP_MODE:
                begin
                    if (q_entry.fan == FAN_W'(i))
                    begin
                        fan_mode_next[i] = q_entry.value[MODE_W-1:0];
                        if (q_entry.value[MODE_W-1:0] == MODE_CURVE)
                        begin
                            level_next[i] = curve_entry(up_reg[i], q_entry.temp);
                        end
                    end
                end
                OP_LEVEL:
                begin
                    if (q_entry.fan == FAN_W'(i))
                    begin
                        level_next[i] = q_entry.value;
                    end
                end
                default:
                begin
                    level_next[i] = level_reg[i];
                end
            endcase
        end
        if (q_entry.op == OP_TICK)
        begin
            if (min_reg == '0 || q_entry.temp < min_reg)
            begin
                min_next = q_entry.temp;
            end
            if (q_entry.temp > max_reg)
            begin
                max_next = q_entry.temp;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FANS; i++)
            begin
                level_reg[i]    <= '0;
                fan_mode_reg[i] <= MODE_AUTO;
            end
            min_reg   <= '0;
            max_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                for (int i = 0; i < NUM_FANS; i++)
                begin
                    level_reg[i]    <= level_next[i];
                    fan_mode_reg[i] <= fan_mode_next[i];
                end
                min_reg <= min_next;
                max_reg <= max_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg[0]   <= RST_FAN12_RAMPUP;
            down_reg[0] <= RST_FAN12_RAMPDOWN;
            up_reg[1]   <= RST_FAN12_RAMPUP;
            down_reg[1] <= RST_FAN12_RAMPDOWN;
            up_reg[2]   <= RST_FAN3_RAMPUP;
            down_reg[2] <= RST_FAN3_RAMPDOWN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAN1_RAMPUP:   up_reg[0]   <= cfg_data;
                CFG_FAN1_RAMPDOWN: down_reg[0] <= cfg_data;
                CFG_FAN2_RAMPUP:   up_reg[1]   <= cfg_data;
                CFG_FAN2_RAMPDOWN: down_reg[1] <= cfg_data;
                CFG_FAN3_RAMPUP:   up_reg[2]   <= cfg_data;
                CFG_FAN3_RAMPDOWN: down_reg[2] <= cfg_data;
                default:
                begin
                    up_reg[0] <= up_reg[0];
                end
            endcase
        end
    end

    assign status.valid          = valid_reg;
    assign status.fan1_level_out = level_reg[0];
    assign status.fan2_level_out = level_reg[1];
    assign status.fan3_level_out = level_reg[2];
    assign status.fan1_mode_out  = fan_mode_reg[0];
    assign status.fan2_mode_out  = fan_mode_reg[1];
    assign status.fan3_mode_out  = fan_mode_reg[2];
    assign status.lowest_temp    = min_reg;
    assign status.highest_temp   = max_reg;

endmodule

// ===== rtl/core/fan_curve_level_controller_unit.sv =====
// ----------------------------------------------------------------------------
// fan_curve_level_controller_unit
// Flow: an accepted request is written into the queue, then popped into the fan
// state and status registers once the status slot is free or being taken.
// Throughput: one request per cycle while the status is taken as offered; the
// back end updates all fan state at once and reloads status as it is taken.
// Reset: levels 0, modes auto, min/max 0, thresholds at their defaults.
// ----------------------------------------------------------------------------
module fan_curve_level_controller_unit #(
    parameter int QUEUE_DEPTH = fclc_pkg::FCLC_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fclc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fclc_pkg::CFG_W-1:0]      cfg_data,
    fclc_cmd_if.sink                        cmd,
    fclc_status_if.source                   status
);
    import fclc_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    fclc_op_t         wr_entry;
    fclc_op_t         rd_entry;
    logic             push;
    logic             pop;
    logic             full;
    logic             not_empty;
    logic [CNT_W-1:0] q_count;

    fclc_front u_front (
        .cmd   (cmd),
        .full  (full),
        .push  (push),
        .entry (wr_entry)
    );

    fclc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (wr_entry),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .rd_entry  (rd_entry),
        .count     (q_count)
    );

    fclc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (not_empty),
        .q_entry   (rd_entry),
        .q_pop     (pop),
        .status    (status)
    );

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> (status.fan1_level_out <= MAX_LEVEL &&
                          status.fan2_level_out <= MAX_LEVEL &&
                          status.fan3_level_out <= MAX_LEVEL))
        else $error("fan level above maximum");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> status.lowest_temp <= status.highest_temp)
        else $error("lowest temperature above highest");

    a_pop_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (not_empty && !status.valid) |-> pop)
        else $error("back end stalled with free status slot");
`endif

endmodule
